/* sv/multi_queue_mailbox_macros.svh */
// assertion macros for the multi queue mailbox
// no dependencies; included by files that carry concurrent checks
`ifndef MULTI_QUEUE_MAILBOX_MACROS_SVH
`define MULTI_QUEUE_MAILBOX_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MQM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MQM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MQM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define MQM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/mqm_pkg.sv */
// types and constants shared by the multi queue mailbox
// no dependencies
`default_nettype none
package mqm_pkg;
    localparam int OPCODE_W = 2;
    localparam int QID_W    = 8;
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = HANDLE_W + SIZE_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SEND   = 2'd0,
        OP_RECV   = 2'd1,
        OP_CREATE = 2'd2,
        OP_DELETE = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BAD_ID = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef struct packed {
        logic in_ready;
        logic eval;
        logic scan;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic accept;
        logic in_create;
        logic scan_end;
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

/* sv/mqm_ifs.sv */
// request and response channel interfaces of the multi queue mailbox
// depends on mqm_pkg
`default_nettype none
interface mqm_req_if;
    logic                          valid;
    logic                          ready;
    logic [mqm_pkg::OPCODE_W-1:0]  opcode;
    logic [mqm_pkg::QID_W-1:0]     target_qid;
    logic [mqm_pkg::HANDLE_W-1:0]  message_handle;
    logic [mqm_pkg::SIZE_W-1:0]    message_size;

    modport source (output valid, opcode, target_qid, message_handle, message_size,
                    input ready);
    modport sink (input valid, opcode, target_qid, message_handle, message_size,
                  output ready);
endinterface

interface mqm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mqm_pkg::STATUS_W-1:0]  status;
    logic [mqm_pkg::QID_W-1:0]     result_qid;
    logic [mqm_pkg::HANDLE_W-1:0]  result_handle;
    logic [mqm_pkg::SIZE_W-1:0]    result_size;

    modport source (output valid, status, result_qid, result_handle, result_size,
                    input ready);
    modport sink (input valid, status, result_qid, result_handle, result_size,
                  output ready);
endinterface
`default_nettype wire

/* sv/mqm_ram.sv */
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module mqm_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire logic [WIDTH-1:0]       i_wdata,
    input  wire logic                   i_re,
    input  wire logic [AW-1:0]          i_raddr,
    output logic      [WIDTH-1:0]       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* sv/mqm_ctrl.sv */
// sequencing state machine of the multi queue mailbox
// depends on mqm_pkg and multi_queue_mailbox_macros.svh
`default_nettype none
`include "multi_queue_mailbox_macros.svh"
module mqm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mqm_pkg::t_sts i_sts,
    output mqm_pkg::t_cmd      o_cmd
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_RESP
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_sts.accept) begin
                        r_state <= i_sts.in_create ? S_SCAN : S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= S_RESP;
                end
                S_SCAN: begin
                    if (i_sts.scan_end) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.in_ready = (r_state == S_IDLE);
        o_cmd.eval     = (r_state == S_EVAL);
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.out_load = (r_state == S_RESP) && i_sts.out_free;
    end

    `MQM_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n,
        i_sts.accept && o_cmd.in_ready, r_state != S_IDLE, "accepted request did not start")
    `MQM_ASSERT_NOW(a_single_cmd, i_clk, i_rst_n, 1'b1,
        $onehot0({o_cmd.in_ready, o_cmd.eval, o_cmd.scan, o_cmd.out_load}),
        "overlapping datapath commands")
    `MQM_ASSERT_NEXT(a_eval_to_resp, i_clk, i_rst_n, o_cmd.eval, r_state == S_RESP,
        "evaluation not followed by response")
    `MQM_ASSERT_NEXT(a_load_to_idle, i_clk, i_rst_n, o_cmd.out_load, o_cmd.in_ready,
        "not ready after response load")
endmodule
`default_nettype wire

/* sv/mqm_datapath.sv */
// pointer table, message store, assignment flags and result registers
// depends on mqm_pkg, mqm_ifs and mqm_ram
`default_nettype none
module mqm_datapath #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int QUEUE_COUNT   = 8,
    parameter int STATIC_QUEUES = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mqm_req_if.sink            i_req,
    mqm_rsp_if.source          o_rsp,
    input  wire mqm_pkg::t_cmd i_cmd,
    output mqm_pkg::t_sts      o_sts
);
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QIDX_W     = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int CNT_W      = $clog2(QUEUE_COUNT + 1);
    localparam int SLOTS      = QUEUE_COUNT * QUEUE_DEPTH;
    localparam int SA_W       = $clog2(SLOTS);
    localparam int SCAN_START = (STATIC_QUEUES < QUEUE_COUNT) ? STATIC_QUEUES : QUEUE_COUNT;
    localparam int QW         = mqm_pkg::QID_W;

    function automatic logic [PTR_W-1:0] f_adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    mqm_pkg::t_opcode              r_op;
    logic [QW-1:0]                 r_qid;
    logic [mqm_pkg::HANDLE_W-1:0]  r_hdl;
    logic [mqm_pkg::SIZE_W-1:0]    r_size;
    logic [CNT_W-1:0]              r_scan;
    logic [QUEUE_COUNT-1:0]        r_pvld;
    logic [QUEUE_COUNT-1:0]        r_assigned;
    mqm_pkg::t_status              r_status;
    logic [QW-1:0]                 r_rq;
    logic                          r_hit;
    logic                          r_ovalid;
    mqm_pkg::t_status              r_o_status;
    logic [QW-1:0]                 r_o_rq;
    logic [mqm_pkg::HANDLE_W-1:0]  r_o_hdl;
    logic [mqm_pkg::SIZE_W-1:0]    r_o_size;

    logic                          accept;
    logic [QIDX_W-1:0]             qidx;
    logic                          qid_ok;
    logic                          static_ok;
    logic [2*PTR_W-1:0]            ptr_q;
    logic [PTR_W-1:0]              wp;
    logic [PTR_W-1:0]              rp;
    logic                          ptr_we;
    logic [2*PTR_W-1:0]            ptr_wdata;
    logic                          st_we;
    logic                          st_re;
    logic [PTR_W-1:0]              slot_ptr;
    logic [SA_W-1:0]               slot_addr;
    logic [mqm_pkg::ENTRY_W-1:0]   st_q;
    mqm_pkg::t_status              n_status;
    logic                          n_hit;
    logic                          del_ok;
    logic [QIDX_W-1:0]             scan_idx;
    logic                          scan_over;
    logic                          scan_free;

    assign accept    = i_req.valid && i_cmd.in_ready;
    assign qidx      = r_qid[QIDX_W-1:0];
    assign qid_ok    = {1'b0, r_qid} < (QW + 1)'(QUEUE_COUNT);
    assign static_ok = {1'b0, r_qid} >= (QW + 1)'(STATIC_QUEUES);
    assign wp        = r_pvld[qidx] ? ptr_q[2*PTR_W-1:PTR_W] : '0;
    assign rp        = r_pvld[qidx] ? ptr_q[PTR_W-1:0] : '0;
    assign slot_addr = SA_W'(qidx) * SA_W'(QUEUE_DEPTH) + SA_W'(slot_ptr);
    assign del_ok    = qid_ok && static_ok;
    assign scan_idx  = r_scan[QIDX_W-1:0];
    assign scan_over = r_scan >= CNT_W'(QUEUE_COUNT);
    assign scan_free = !scan_over && !r_assigned[scan_idx];

    always_comb begin
        ptr_we    = 1'b0;
        ptr_wdata = {wp, rp};
        st_we     = 1'b0;
        st_re     = 1'b0;
        slot_ptr  = wp;
        n_status  = mqm_pkg::ST_OK;
        n_hit     = 1'b0;
        if (i_cmd.eval) begin
            unique case (r_op)
                mqm_pkg::OP_SEND: begin
                    if (!qid_ok) begin
                        n_status = mqm_pkg::ST_BAD_ID;
                    end else if (f_adv(wp) == rp) begin
                        n_status = mqm_pkg::ST_FULL;
                    end else begin
                        st_we     = 1'b1;
                        ptr_we    = 1'b1;
                        ptr_wdata = {f_adv(wp), rp};
                    end
                end
                mqm_pkg::OP_RECV: begin
                    slot_ptr = rp;
                    if (!qid_ok) begin
                        n_status = mqm_pkg::ST_BAD_ID;
                    end else if (rp == wp) begin
                        n_status = mqm_pkg::ST_EMPTY;
                    end else begin
                        st_re     = 1'b1;
                        n_hit     = 1'b1;
                        ptr_we    = 1'b1;
                        ptr_wdata = {wp, f_adv(rp)};
                    end
                end
                mqm_pkg::OP_DELETE: begin
                    if (!del_ok) begin
                        n_status = mqm_pkg::ST_BAD_ID;
                    end
                end
                mqm_pkg::OP_CREATE: begin
                    n_status = mqm_pkg::ST_OK;
                end
                default: begin
                    n_status = mqm_pkg::ST_OK;
                end
            endcase
        end
    end

    mqm_ram #(
        .WIDTH (2 * PTR_W),
        .DEPTH (QUEUE_COUNT)
    ) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (ptr_we),
        .i_waddr (qidx),
        .i_wdata (ptr_wdata),
        .i_re    (accept),
        .i_raddr (i_req.target_qid[QIDX_W-1:0]),
        .o_rdata (ptr_q)
    );

    mqm_ram #(
        .WIDTH (mqm_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (slot_addr),
        .i_wdata ({r_hdl, r_size}),
        .i_re    (st_re),
        .i_raddr (slot_addr),
        .o_rdata (st_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld     <= '0;
            r_assigned <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (ptr_we) begin
                r_pvld[qidx] <= 1'b1;
            end
            if (i_cmd.eval && (r_op == mqm_pkg::OP_DELETE) && del_ok) begin
                r_assigned[qidx] <= 1'b0;
            end
            if (i_cmd.scan && scan_free) begin
                r_assigned[scan_idx] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= mqm_pkg::t_opcode'(i_req.opcode);
            r_qid    <= i_req.target_qid;
            r_hdl    <= i_req.message_handle;
            r_size   <= i_req.message_size;
            r_scan   <= CNT_W'(SCAN_START);
            r_status <= mqm_pkg::ST_OK;
            r_rq     <= '0;
            r_hit    <= 1'b0;
        end
        if (i_cmd.eval) begin
            r_status <= n_status;
            r_hit    <= n_hit;
        end
        if (i_cmd.scan) begin
            if (scan_free) begin
                r_status <= mqm_pkg::ST_OK;
                r_rq     <= QW'(r_scan);
            end else if (scan_over) begin
                r_status <= mqm_pkg::ST_FULL;
            end else begin
                r_scan <= r_scan + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_rq     <= r_rq;
            r_o_hdl    <= r_hit ? st_q[mqm_pkg::ENTRY_W-1:mqm_pkg::SIZE_W] : '0;
            r_o_size   <= r_hit ? st_q[mqm_pkg::SIZE_W-1:0] : '0;
        end
    end

    assign i_req.ready         = i_cmd.in_ready;
    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.result_qid    = r_o_rq;
    assign o_rsp.result_handle = r_o_hdl;
    assign o_rsp.result_size   = r_o_size;

    always_comb begin
        o_sts.accept    = accept;
        o_sts.in_create = (i_req.opcode == mqm_pkg::OP_CREATE);
        o_sts.scan_end  = scan_over || scan_free;
        o_sts.out_free  = !r_ovalid || o_rsp.ready;
    end
endmodule
`default_nettype wire

/* sv/multi_queue_mailbox.sv */
// top level of the multi queue mailbox: controller plus datapath
// depends on mqm_pkg, mqm_ifs, mqm_ctrl and mqm_datapath
//
// channel  dir  carries
// i_req    in   opcode, target_qid, message_handle, message_size
// o_rsp    out  status, result_qid, result_handle, result_size
//
// send, receive, delete: pointer ram read at accept, then update, then response load
// create: the same, with a one-per-cycle scan over the assignment flags in place of the update
// one request at a time; a waiting response holds the block in its response state
// synchronous active-low reset clears pointer valid bits, assignment flags and control
`default_nettype none
module multi_queue_mailbox #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int QUEUE_COUNT   = 8,
    parameter int STATIC_QUEUES = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mqm_req_if.sink   i_req,
    mqm_rsp_if.source o_rsp
);
    mqm_pkg::t_cmd cmd;
    mqm_pkg::t_sts sts;

    mqm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mqm_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .QUEUE_COUNT   (QUEUE_COUNT),
        .STATIC_QUEUES (STATIC_QUEUES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );
endmodule
`default_nettype wire

/* tb/sv/mqm_reply_checker.sv */
// checker for the multi queue mailbox: watches the request and response channels,
// predicts each response from its own copy of the queues and compares field by field
// depends on mqm_pkg and mqm_ifs
`timescale 1ns / 1ps
module mqm_reply_checker #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int QUEUE_COUNT   = 8,
    parameter int STATIC_QUEUES = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mqm_req_if   i_req,
    mqm_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import mqm_pkg::*;

    typedef struct packed {
        t_status               status;
        logic [QID_W-1:0]      grant_qid;
        logic [HANDLE_W-1:0]   handle;
        logic [SIZE_W-1:0]     size;
    } t_reply;

    logic [HANDLE_W-1:0] handle_mem [QUEUE_COUNT*QUEUE_DEPTH];
    logic [SIZE_W-1:0]   size_mem   [QUEUE_COUNT*QUEUE_DEPTH];
    int unsigned         wr_ptr     [QUEUE_COUNT];
    int unsigned         rd_ptr     [QUEUE_COUNT];
    logic                assigned   [QUEUE_COUNT];
    t_reply              expected_replies [$];

    function automatic t_reply mailbox_reply(t_opcode op, logic [QID_W-1:0] qid,
                                             logic [HANDLE_W-1:0] hdl,
                                             logic [SIZE_W-1:0] sz);
        t_reply      r;
        int unsigned nxt;
        logic        found;
        r = '0;
        r.status = ST_OK;
        found = 1'b0;
        case (op)
            OP_SEND: begin
                if (qid >= QUEUE_COUNT) begin
                    r.status = ST_BAD_ID;
                end else begin
                    nxt = (wr_ptr[qid] + 1) % QUEUE_DEPTH;
                    if (nxt == rd_ptr[qid]) begin
                        r.status = ST_FULL;
                    end else begin
                        handle_mem[qid*QUEUE_DEPTH + wr_ptr[qid]] = hdl;
                        size_mem[qid*QUEUE_DEPTH + wr_ptr[qid]]   = sz;
                        wr_ptr[qid] = nxt;
                    end
                end
            end
            OP_RECV: begin
                if (qid >= QUEUE_COUNT) begin
                    r.status = ST_BAD_ID;
                end else if (rd_ptr[qid] == wr_ptr[qid]) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.handle = handle_mem[qid*QUEUE_DEPTH + rd_ptr[qid]];
                    r.size   = size_mem[qid*QUEUE_DEPTH + rd_ptr[qid]];
                    rd_ptr[qid] = (rd_ptr[qid] + 1) % QUEUE_DEPTH;
                end
            end
            OP_CREATE: begin
                r.status = ST_FULL;
                for (int i = STATIC_QUEUES; i < QUEUE_COUNT; i++) begin
                    if (!found && !assigned[i]) begin
                        found       = 1'b1;
                        assigned[i] = 1'b1;
                        r.grant_qid = QID_W'(i);
                        r.status    = ST_OK;
                    end
                end
            end
            default: begin
                if (qid < STATIC_QUEUES || qid >= QUEUE_COUNT) begin
                    r.status = ST_BAD_ID;
                end else begin
                    assigned[qid] = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_reply exp_r;
        if (!i_rst_n) begin
            for (int q = 0; q < QUEUE_COUNT; q++) begin
                wr_ptr[q]   = 0;
                rd_ptr[q]   = 0;
                assigned[q] = 1'b0;
            end
            expected_replies.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_replies.size() == 0) begin
                    $error("response with no request outstanding");
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_r = expected_replies.pop_front();
                    if (i_rsp.status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, i_rsp.status);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp.result_qid !== exp_r.grant_qid) begin
                        $error("result_qid: expected %0d, got %0d",
                               exp_r.grant_qid, i_rsp.result_qid);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp.result_handle !== exp_r.handle) begin
                        $error("result_handle: expected %h, got %h",
                               exp_r.handle, i_rsp.result_handle);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp.result_size !== exp_r.size) begin
                        $error("result_size: expected %h, got %h",
                               exp_r.size, i_rsp.result_size);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_replies.push_back(mailbox_reply(t_opcode'(i_req.opcode),
                    i_req.target_qid, i_req.message_handle, i_req.message_size));
            end
        end
        o_pending = expected_replies.size();
    end
endmodule

/* tb/sv/tb_multi_queue_mailbox.sv */
// top of the multi queue mailbox testbench: clock, reset, request stimulus and
// response back-pressure; depends on mqm_pkg, mqm_ifs, mqm_reply_checker and the block
`timescale 1ns / 1ps
module tb_multi_queue_mailbox;
    import mqm_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int QUEUE_COUNT   = 8;
    localparam int STATIC_QUEUES = 4;
    localparam int ITEMS_TOTAL   = 1050;
    localparam int QUIET_TAIL    = 150;

    logic i_clk;
    logic i_rst_n;
    logic idle_on;
    int   requests_sent;
    int   rsp_stall_left;
    int   fail_count;
    int   pending;

    mqm_req_if req_if ();
    mqm_rsp_if rsp_if ();

    multi_queue_mailbox #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .QUEUE_COUNT   (QUEUE_COUNT),
        .STATIC_QUEUES (STATIC_QUEUES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    mqm_reply_checker #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .QUEUE_COUNT   (QUEUE_COUNT),
        .STATIC_QUEUES (STATIC_QUEUES)
    ) u_reply_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // response back-pressure in random bursts
    always @(negedge i_clk) begin
        if (rsp_stall_left > 0) begin
            rsp_if.ready   <= 1'b0;
            rsp_stall_left <= rsp_stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_if.ready   <= 1'b0;
            rsp_stall_left <= $urandom_range(0, 13);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic issue_request(t_opcode op, logic [QID_W-1:0] qid,
                                 logic [HANDLE_W-1:0] hdl, logic [SIZE_W-1:0] sz);
        int gap;
        gap = 0;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.opcode         <= op;
        req_if.target_qid     <= qid;
        req_if.message_handle <= hdl;
        req_if.message_size   <= sz;
        forever begin
            @(posedge i_clk);
            if (req_if.ready) break;
        end
        requests_sent++;
    endtask

    task automatic random_request(t_opcode op, logic [QID_W-1:0] qid);
        issue_request(op, qid, $urandom, SIZE_W'($urandom_range(0, 65535)));
    endtask

    initial begin
        int kind;
        int n;
        int q;
        idle_on               = 1'b1;
        requests_sent         = 0;
        rsp_stall_left        = 0;
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.opcode         = OP_SEND;
        req_if.target_qid     = '0;
        req_if.message_handle = '0;
        req_if.message_size   = '0;
        rsp_if.ready          = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, extremes, bad ids, create exhaustion, delete cases
        issue_request(OP_RECV, 8'd0, '0, '0);
        issue_request(OP_SEND, 8'd0, 32'h0000_0000, 16'h0000);
        issue_request(OP_RECV, 8'd0, '1, '1);
        issue_request(OP_SEND, 8'd7, 32'hFFFF_FFFF, 16'hFFFF);
        issue_request(OP_RECV, 8'd7, '0, '0);
        issue_request(OP_SEND, 8'd8, 32'hA5A5_5A5A, 16'h1234);
        issue_request(OP_RECV, 8'd255, '0, '0);
        repeat (5) issue_request(OP_CREATE, 8'd255, '0, '0);
        issue_request(OP_DELETE, 8'd3, '0, '0);
        issue_request(OP_DELETE, 8'd255, '0, '0);
        issue_request(OP_DELETE, 8'd5, '0, '0);
        issue_request(OP_DELETE, 8'd5, '0, '0);
        issue_request(OP_CREATE, 8'd0, '0, '0);

        // random bursts: fills, drains, mixed traffic, create/delete churn, noise
        while (requests_sent < ITEMS_TOTAL) begin
            idle_on = (requests_sent < ITEMS_TOTAL - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            q    = $urandom_range(0, QUEUE_COUNT - 1);
            case (kind)
                0, 1, 2: begin
                    n = $urandom_range(8, 18);
                    repeat (n) random_request(OP_SEND, QID_W'(q));
                end
                3, 4, 5: begin
                    n = $urandom_range(8, 18);
                    repeat (n) random_request(OP_RECV, QID_W'(q));
                end
                6, 7: begin
                    n = $urandom_range(5, 20);
                    repeat (n) random_request(t_opcode'($urandom_range(0, 3)),
                                              QID_W'($urandom_range(0, QUEUE_COUNT - 1)));
                end
                8: begin
                    n = $urandom_range(4, 12);
                    repeat (n) random_request($urandom_range(0, 1) ? OP_CREATE : OP_DELETE,
                                              QID_W'($urandom_range(0, QUEUE_COUNT + 1)));
                end
                default: begin
                    n = $urandom_range(2, 8);
                    repeat (n) random_request(t_opcode'($urandom_range(0, 3)),
                                              QID_W'($urandom_range(0, 255)));
                end
            endcase
        end

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
